>>> design/brm_pkg.sv
// shared types and constants of the bus activity rate monitor
package brm_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned WLEN_W     = 16;
    localparam int unsigned DIVIDEND_W = 42;
    localparam int unsigned DIV_CNT_W  = 6;
    localparam int unsigned ADDR_W     = 3;

    localparam logic [DATA_W-1:0]  MS_PER_SECOND  = 32'd1000;
    localparam logic [1:0]         STALE_WINDOWS  = 2'd2;
    localparam logic [WLEN_W-1:0]  WLEN_RESET     = 16'd1000;
    localparam logic               REG_WINDOW_LEN = 1'b0;

    typedef enum logic [1:0] {
        OP_SUCCESS = 2'd0,
        OP_FAIL    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REPORT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WIN,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DATA_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> design/brm_div.sv
// iterative restoring divider, one quotient bit per cycle
module brm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brm_pkg::t_div_req i_req,
    output brm_pkg::t_div_rsp o_rsp
);
    import brm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]       r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DATA_W-1:0]     r_dsr;

    logic [DATA_W:0]       w_rem_sh;
    logic [DATA_W+1:0]     w_diff;

    assign w_rem_sh = {r_rem[DATA_W-1:0], r_quo[DIVIDEND_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[DATA_W+1]) begin
                r_rem <= w_diff[DATA_W:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> design/bus_activity_rate_monitor.sv
// top level of the bus activity rate monitor
//
// Each item is a bus event (success, failure, clear or report) stamped with a
// millisecond time, and yields one result item with the counters, the peak
// rate, the time since clear and the current window rate. An item passes from
// idle through evaluation to done, where its result is loaded; a success also
// passes the window state, and one that closes a rate window waits in the
// divide state for an iterative divider that yields one of 42 quotient bits
// per cycle. The input is ready again the cycle after the result is loaded,
// so no new item is taken before the last is through; it is accepted while
// a result still waits on the output. Per-channel counts live in a small
// memory with one valid bit per channel, so a clear takes effect at once. The
// window length register sits at byte addresses 0 to 3 of the config port.
module bus_activity_rate_monitor #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brm_pkg::ADDR_W-1:0]  paddr,
    input  logic [brm_pkg::DATA_W-1:0]  pwdata,
    output logic [brm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [31:0]                 i_time_ms,
    input  logic [2:0]                  i_channel,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [31:0]                 o_total_ops,
    output logic [31:0]                 o_failed_ops,
    output logic [31:0]                 o_channel_ops,
    output logic [31:0]                 o_rate_hz,
    output logic [31:0]                 o_peak_hz,
    output logic [31:0]                 o_since_clear_ms
);
    import brm_pkg::*;

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [8:0]  NCH   = 9'(NUM_CHANNELS);

    t_state r_state;
    t_state n_state;

    logic [WLEN_W-1:0] r_win_len;
    logic [WLEN_W-1:0] w_eff;

    t_op               r_op;
    logic [DATA_W-1:0] r_time;
    logic [IDX_W-1:0]  r_idx;
    logic              r_in_rng;

    logic [DATA_W-1:0] r_total;
    logic [DATA_W-1:0] r_failed;
    logic [DATA_W-1:0] r_win_start;
    logic [DATA_W-1:0] r_win_count;
    logic [DATA_W-1:0] r_last_rate;
    logic [DATA_W-1:0] r_peak;
    logic [DATA_W-1:0] r_since;
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] r_chan_val;
    logic [DIVIDEND_W-1:0] r_dividend;

    logic [DATA_W-1:0] r_chan_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_chan_vld;
    logic [DATA_W-1:0] r_rd_data;

    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_total;
    logic [DATA_W-1:0] r_out_failed;
    logic [DATA_W-1:0] r_out_chan;
    logic [DATA_W-1:0] r_out_rate;
    logic [DATA_W-1:0] r_out_peak;
    logic [DATA_W-1:0] r_out_elapsed;

    logic              w_accept;
    logic              w_load;
    logic [8:0]        w_ch_ext;
    logic              w_in_rng;
    logic [IDX_W-1:0]  w_in_idx;
    logic [DATA_W-1:0] w_ch_cnt;
    logic [DATA_W-1:0] w_stamp;
    logic [DATA_W-1:0] w_ws;
    logic [DIVIDEND_W-1:0] w_mul;
    logic              w_close;
    logic [DATA_W-1:0] w_sat;
    logic [DATA_W-1:0] w_age;
    logic              w_mem_we;
    logic              w_cfg_wr;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
    assign prdata   = (paddr[2] == REG_WINDOW_LEN) ? {{(DATA_W-WLEN_W){1'b0}}, r_win_len} : '0;
    assign w_eff    = (r_win_len == '0) ? WLEN_W'(1) : r_win_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WLEN_RESET;
        end else if (w_cfg_wr) begin
            r_win_len <= pwdata[WLEN_W-1:0];
        end
    end

    // input decode
    assign w_accept = i_in_valid && o_in_ready;
    assign w_ch_ext = {6'b0, i_channel};
    assign w_in_rng = w_ch_ext < NCH;
    assign w_in_idx = w_ch_ext[IDX_W-1:0];

    // per-channel count memory
    assign w_ch_cnt = r_chan_vld[r_idx] ? r_rd_data : '0;
    assign w_mem_we = (r_state == ST_EVAL) && (r_op == OP_SUCCESS) && r_in_rng;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_chan_mem[r_idx] <= w_ch_cnt + 1'b1;
        end
        if (w_accept) begin
            r_rd_data <= r_chan_mem[w_in_idx];
        end
    end

    // window arithmetic
    assign w_stamp = (r_time == '0) ? DATA_W'(1) : r_time;
    assign w_ws    = (r_win_start == '0) ? w_stamp : r_win_start;
    assign w_mul   = DIVIDEND_W'({r_win_count, 10'b0})
                   - DIVIDEND_W'({r_win_count, 4'b0})
                   - DIVIDEND_W'({r_win_count, 3'b0});
    assign w_close = r_span >= DATA_W'(w_eff);
    assign w_sat   = (w_div_rsp.quotient[DIVIDEND_W-1:DATA_W] != '0) ? '1
                   : w_div_rsp.quotient[DATA_W-1:0];
    assign w_age   = r_time - r_win_start;

    assign w_div_req.start    = (r_state == ST_WIN) && w_close;
    assign w_div_req.dividend = r_dividend;
    assign w_div_req.divisor  = r_span;

    brm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = (r_op == OP_SUCCESS) ? ST_WIN : ST_DONE;
            end
            ST_WIN: begin
                n_state = w_close ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_failed    <= '0;
            r_win_start <= '0;
            r_win_count <= '0;
            r_last_rate <= '0;
            r_peak      <= '0;
            r_since     <= '0;
            r_chan_vld  <= '0;
        end else begin
            case (r_state)
                ST_EVAL: begin
                    case (r_op)
                        OP_SUCCESS: begin
                            r_total     <= r_total + 1'b1;
                            r_win_start <= w_ws;
                            if (r_in_rng) begin
                                r_chan_vld[r_idx] <= 1'b1;
                            end
                        end
                        OP_FAIL: begin
                            r_failed <= r_failed + 1'b1;
                        end
                        OP_CLEAR: begin
                            r_total     <= '0;
                            r_failed    <= '0;
                            r_win_start <= '0;
                            r_win_count <= '0;
                            r_last_rate <= '0;
                            r_peak      <= '0;
                            r_since     <= r_time;
                            r_chan_vld  <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_WIN: begin
                    if (w_close) begin
                        r_win_start <= w_stamp;
                        r_win_count <= DATA_W'(1);
                    end else begin
                        r_win_count <= r_win_count + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_last_rate <= w_sat;
                        if (w_sat > r_peak) begin
                            r_peak <= w_sat;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(i_op);
            r_time   <= i_time_ms;
            r_idx    <= w_in_idx;
            r_in_rng <= w_in_rng;
        end
        if (r_state == ST_EVAL) begin
            r_span     <= r_time - w_ws;
            r_dividend <= w_mul;
            if (!r_in_rng || r_op == OP_CLEAR) begin
                r_chan_val <= '0;
            end else if (r_op == OP_SUCCESS) begin
                r_chan_val <= w_ch_cnt + 1'b1;
            end else begin
                r_chan_val <= w_ch_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_total   <= r_total;
            r_out_failed  <= r_failed;
            r_out_chan    <= r_chan_val;
            r_out_peak    <= r_peak;
            r_out_elapsed <= r_time - r_since;
            if ((r_win_start != '0)
                && (w_age < DATA_W'(DATA_W'(w_eff) * DATA_W'(STALE_WINDOWS)))) begin
                r_out_rate <= r_last_rate;
            end else begin
                r_out_rate <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_total_ops      = r_out_total;
    assign o_failed_ops     = r_out_failed;
    assign o_channel_ops    = r_out_chan;
    assign o_rate_hz        = r_out_rate;
    assign o_peak_hz        = r_out_peak;
    assign o_since_clear_ms = r_out_elapsed;

endmodule
